/* rtl/core/segment_line_classify_split_top_assert.svh */
// assertion macros for the segment line classify and split block
// no dependencies; included by the top level only
`ifndef SEGMENT_LINE_CLASSIFY_SPLIT_TOP_ASSERT_SVH
`define SEGMENT_LINE_CLASSIFY_SPLIT_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SLCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SLCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/slcs_pkg.sv */
// shared widths, codes, stage map and payload types of the segment classifier
// no dependencies; used by the interfaces, the divider and the top level
package slcs_pkg;

    // field widths
    localparam int COORD_W    = 16;
    localparam int NORM_W     = 16;
    localparam int OFFS_W     = 32;
    localparam int THK_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // datapath widths
    localparam int PROD_W   = 32;   // normal times coordinate
    localparam int DIST_W   = 34;   // signed distance
    localparam int DIFF_W   = 35;   // distance difference
    localparam int DENM_W   = 34;   // magnitude of distance difference
    localparam int D1M_W    = 33;   // magnitude of end distance
    localparam int DCD_W    = COORD_W + 1;   // coordinate difference
    localparam int DCM_W    = 16;   // magnitude of coordinate difference
    localparam int PP_SPLIT = 17;   // low slice of end distance magnitude
    localparam int PPLO_W   = DCM_W + PP_SPLIT;
    localparam int PPHI_W   = DCM_W + D1M_W - PP_SPLIT;
    localparam int AN_W     = 49;   // product magnitude
    localparam int NUM_W    = 50;   // rounded dividend
    localparam int DEN_W    = 35;   // doubled divisor
    localparam int QUO_W    = 16;   // quotient bits, one per divider stage

    // stage map
    localparam int ST_PROD = 0;
    localparam int ST_SUM  = 1;
    localparam int ST_CLS  = 2;
    localparam int ST_PP   = 3;
    localparam int ST_ND   = 4;
    localparam int ST_DIV0 = 5;
    localparam int NST     = ST_DIV0 + QUO_W + 1;

    // register reset values
    localparam logic signed [NORM_W-1:0] NORMAL_X_RST    = 16'sd16384;
    localparam logic signed [NORM_W-1:0] NORMAL_Y_RST    = 16'sd0;
    localparam logic signed [OFFS_W-1:0] LINE_OFFSET_RST = 32'sd0;
    localparam logic [THK_W-1:0]         THICKNESS_RST   = 20'd4194;

    typedef enum logic [1:0] {
        CODE_FRONT = 2'd0,
        CODE_BACK  = 2'd1,
        CODE_ON    = 2'd2,
        CODE_CUT   = 2'd3
    } t_side_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X    = 2'd0,
        CFG_NORMAL_Y    = 2'd1,
        CFG_LINE_OFFSET = 2'd2,
        CFG_THICKNESS   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
    } t_seg;

    typedef struct packed {
        t_side_code code;
        logic       start_front;
        logic       neg_x;
        logic       neg_y;
        t_seg       seg;
    } t_side;

    typedef struct packed {
        t_side_code code;
        t_seg       kept;
        t_seg       piece;
    } t_res;

endpackage

/* rtl/core/slcs_seg_if.sv */
// segment input channel: valid, ready and the two endpoints
// depends on slcs_pkg
interface slcs_seg_if;
    logic                               valid;
    logic                               ready;
    logic signed [slcs_pkg::COORD_W-1:0] start_x;
    logic signed [slcs_pkg::COORD_W-1:0] start_y;
    logic signed [slcs_pkg::COORD_W-1:0] end_x;
    logic signed [slcs_pkg::COORD_W-1:0] end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

/* rtl/core/slcs_res_if.sv */
// result channel: valid, ready, side code, kept segment and split-off piece
// depends on slcs_pkg
interface slcs_res_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         side_code;
    logic signed [slcs_pkg::COORD_W-1:0] kept_x0;
    logic signed [slcs_pkg::COORD_W-1:0] kept_y0;
    logic signed [slcs_pkg::COORD_W-1:0] kept_x1;
    logic signed [slcs_pkg::COORD_W-1:0] kept_y1;
    logic signed [slcs_pkg::COORD_W-1:0] piece_x0;
    logic signed [slcs_pkg::COORD_W-1:0] piece_y0;
    logic signed [slcs_pkg::COORD_W-1:0] piece_x1;
    logic signed [slcs_pkg::COORD_W-1:0] piece_y1;

    modport source (output valid, output side_code, output kept_x0, output kept_y0,
                    output kept_x1, output kept_y1, output piece_x0, output piece_y0,
                    output piece_x1, output piece_y1, input ready);
    modport sink (input valid, input side_code, input kept_x0, input kept_y0,
                  input kept_x1, input kept_y1, input piece_x0, input piece_y0,
                  input piece_x1, input piece_y1, output ready);
endinterface

/* rtl/core/slcs_cfg_if.sv */
// configuration write channel: valid, ready, register index and write data
// depends on slcs_pkg
interface slcs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [slcs_pkg::CFG_IDX_W-1:0]    index;
    logic [slcs_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/segment_line_classify_split_top.sv */
// top level of the segment against line classifier and splitter
// depends on slcs_pkg, the three channel interfaces, slcs_div and the assert header
//
// Usage: segments come in on i_seg (start and end points, signed Q8.8) and one
// result per segment leaves on o_res: a side code (front, back, on line, split),
// the kept segment and, for a split, the back piece. The line is loaded through
// i_cfg: normal x and y (Q2.14), offset and band half width (Q.22). Config
// must be written by the user only while no segment is in flight; the block
// does not enforce this; i_cfg.ready is always high. A segment crosses 22 register
// stages, the first loaded by its transfer in; one segment can be taken every
// cycle unless o_res stalls. The depth comes from the crossing point division:
// a 16-stage restoring divider, one quotient bit per stage, behind five stages
// of products, distances, classification and scaling, then one output register.
// Each stage holds its item when the next one is full and stalled, so a stall
// at o_res fills the bubbles first and only then pulls i_seg.ready low; no
// item is lost or repeated. Reset (synchronous, active low) empties the
// pipeline and loads the default line: normal (1, 0), offset 0, band 0.001.
`include "segment_line_classify_split_top_assert.svh"

module segment_line_classify_split_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    slcs_seg_if.sink        i_seg,
    slcs_res_if.source      o_res,
    slcs_cfg_if.sink        i_cfg
);

    // configuration registers
    logic signed [slcs_pkg::NORM_W-1:0] r_normal_x;
    logic signed [slcs_pkg::NORM_W-1:0] r_normal_y;
    logic signed [slcs_pkg::OFFS_W-1:0] r_line_offset;
    logic [slcs_pkg::THK_W-1:0]         r_thickness;

    // flow control
    logic [slcs_pkg::NST-1:0] r_vld;
    logic [slcs_pkg::NST-1:0] w_en;

    // products stage
    logic signed [slcs_pkg::PROD_W-1:0] n_p0x, n_p0y, n_p1x, n_p1y;
    logic signed [slcs_pkg::PROD_W-1:0] r_p0x, r_p0y, r_p1x, r_p1y;
    slcs_pkg::t_seg                     n_seg_pr, r_seg_pr;

    // distance stage
    logic signed [slcs_pkg::DIST_W-1:0] n_d0, n_d1, r_d0, r_d1;
    slcs_pkg::t_seg                     r_seg_sm;

    // classify stage
    logic signed [slcs_pkg::DIST_W-1:0] w_thk;
    logic                               w_fr0, w_bk0, w_fr1, w_bk1;
    logic signed [slcs_pkg::DIFF_W-1:0] w_den, w_den_abs;
    logic signed [slcs_pkg::DIST_W-1:0] w_d1_abs;
    logic signed [slcs_pkg::DCD_W-1:0]  w_dcx, w_dcy, w_dcx_abs, w_dcy_abs;
    slcs_pkg::t_side                    n_side_cl, r_side_cl;
    logic [slcs_pkg::DENM_W-1:0]        r_adm_cl;
    logic [slcs_pkg::D1M_W-1:0]         r_ad1_cl;
    logic [slcs_pkg::DCM_W-1:0]         r_dcx_cl, r_dcy_cl;

    // partial product stage
    logic [slcs_pkg::PPLO_W-1:0]        r_pplo_x, r_pplo_y;
    logic [slcs_pkg::PPHI_W-1:0]        r_pphi_x, r_pphi_y;
    logic [slcs_pkg::DENM_W-1:0]        r_adm_pp;
    slcs_pkg::t_side                    r_side_pp;

    // dividend and divisor stage
    logic [slcs_pkg::AN_W-1:0]          w_an_x, w_an_y;
    logic [slcs_pkg::NUM_W-1:0]         r_num_x, r_num_y;
    logic [slcs_pkg::DEN_W-1:0]         r_den_nd;
    slcs_pkg::t_side                    r_side_nd;

    // divider stages and output
    slcs_pkg::t_side                    r_side_dv [slcs_pkg::QUO_W];
    logic [slcs_pkg::QUO_W-1:0]         w_qx, w_qy;
    logic signed [slcs_pkg::COORD_W-1:0] w_cx, w_cy;
    slcs_pkg::t_side                    w_last;
    slcs_pkg::t_res                     n_out, r_out;

    // terms watched by the assertions
    logic                               w_chk_cut, w_chk_whole, w_cut_joins;
    logic                               w_piece_clear, w_seg_take;

    // configuration writes, always accepted
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_x    <= slcs_pkg::NORMAL_X_RST;
            r_normal_y    <= slcs_pkg::NORMAL_Y_RST;
            r_line_offset <= slcs_pkg::LINE_OFFSET_RST;
            r_thickness   <= slcs_pkg::THICKNESS_RST;
        end else if (i_cfg.valid) begin
            case (slcs_pkg::t_cfg_idx'(i_cfg.index))
                slcs_pkg::CFG_NORMAL_X: begin
                    r_normal_x <= i_cfg.data[slcs_pkg::NORM_W-1:0];
                end
                slcs_pkg::CFG_NORMAL_Y: begin
                    r_normal_y <= i_cfg.data[slcs_pkg::NORM_W-1:0];
                end
                slcs_pkg::CFG_LINE_OFFSET: begin
                    r_line_offset <= i_cfg.data[slcs_pkg::OFFS_W-1:0];
                end
                slcs_pkg::CFG_THICKNESS: begin
                    r_thickness <= i_cfg.data[slcs_pkg::THK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // stage enables: a stage loads when it is empty or its successor moves
    always_comb begin
        w_en[slcs_pkg::NST-1] = !r_vld[slcs_pkg::NST-1] || o_res.ready;
        for (int s = slcs_pkg::NST - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign i_seg.ready = w_en[slcs_pkg::ST_PROD];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[slcs_pkg::ST_PROD]) begin
                r_vld[slcs_pkg::ST_PROD] <= i_seg.valid;
            end
            for (int s = 1; s < slcs_pkg::NST; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // normal times coordinate products
    assign n_p0x = r_normal_x * i_seg.start_x;
    assign n_p0y = r_normal_y * i_seg.start_y;
    assign n_p1x = r_normal_x * i_seg.end_x;
    assign n_p1y = r_normal_y * i_seg.end_y;
    assign n_seg_pr = '{x0: i_seg.start_x, y0: i_seg.start_y,
                        x1: i_seg.end_x, y1: i_seg.end_y};

    always_ff @(posedge i_clk) begin
        if (w_en[slcs_pkg::ST_PROD]) begin
            r_p0x    <= n_p0x;
            r_p0y    <= n_p0y;
            r_p1x    <= n_p1x;
            r_p1y    <= n_p1y;
            r_seg_pr <= n_seg_pr;
        end
    end

    // signed distances of both endpoints
    assign n_d0 = slcs_pkg::DIST_W'(r_p0x) + slcs_pkg::DIST_W'(r_p0y)
                + slcs_pkg::DIST_W'(r_line_offset);
    assign n_d1 = slcs_pkg::DIST_W'(r_p1x) + slcs_pkg::DIST_W'(r_p1y)
                + slcs_pkg::DIST_W'(r_line_offset);

    always_ff @(posedge i_clk) begin
        if (w_en[slcs_pkg::ST_SUM]) begin
            r_d0     <= n_d0;
            r_d1     <= n_d1;
            r_seg_sm <= r_seg_pr;
        end
    end

    // endpoint sides against the band, and division operand magnitudes
    assign w_thk = $signed(slcs_pkg::DIST_W'(r_thickness));
    assign w_fr0 = (r_d0 > w_thk);
    assign w_bk0 = (r_d0 < -w_thk);
    assign w_fr1 = (r_d1 > w_thk);
    assign w_bk1 = (r_d1 < -w_thk);

    assign w_den     = slcs_pkg::DIFF_W'(r_d1) - slcs_pkg::DIFF_W'(r_d0);
    assign w_den_abs = w_den[slcs_pkg::DIFF_W-1] ? -w_den : w_den;
    assign w_d1_abs  = r_d1[slcs_pkg::DIST_W-1] ? -r_d1 : r_d1;
    assign w_dcx     = slcs_pkg::DCD_W'(r_seg_sm.x0) - slcs_pkg::DCD_W'(r_seg_sm.x1);
    assign w_dcy     = slcs_pkg::DCD_W'(r_seg_sm.y0) - slcs_pkg::DCD_W'(r_seg_sm.y1);
    assign w_dcx_abs = w_dcx[slcs_pkg::DCD_W-1] ? -w_dcx : w_dcx;
    assign w_dcy_abs = w_dcy[slcs_pkg::DCD_W-1] ? -w_dcy : w_dcy;

    always_comb begin
        n_side_cl.seg         = r_seg_sm;
        n_side_cl.start_front = w_fr0;
        n_side_cl.neg_x = w_dcx[slcs_pkg::DCD_W-1] ^ r_d1[slcs_pkg::DIST_W-1]
                        ^ w_den[slcs_pkg::DIFF_W-1];
        n_side_cl.neg_y = w_dcy[slcs_pkg::DCD_W-1] ^ r_d1[slcs_pkg::DIST_W-1]
                        ^ w_den[slcs_pkg::DIFF_W-1];
        if ((w_fr0 && w_bk1) || (w_bk0 && w_fr1)) begin
            n_side_cl.code = slcs_pkg::CODE_CUT;
        end else if (!w_fr0 && !w_bk0 && !w_fr1 && !w_bk1) begin
            n_side_cl.code = slcs_pkg::CODE_ON;
        end else if (w_fr0 || w_fr1) begin
            n_side_cl.code = slcs_pkg::CODE_FRONT;
        end else begin
            n_side_cl.code = slcs_pkg::CODE_BACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[slcs_pkg::ST_CLS]) begin
            r_side_cl <= n_side_cl;
            r_adm_cl  <= w_den_abs[slcs_pkg::DENM_W-1:0];
            r_ad1_cl  <= w_d1_abs[slcs_pkg::D1M_W-1:0];
            r_dcx_cl  <= w_dcx_abs[slcs_pkg::DCM_W-1:0];
            r_dcy_cl  <= w_dcy_abs[slcs_pkg::DCM_W-1:0];
        end
    end

    // coordinate difference times end distance, split in two narrow products
    always_ff @(posedge i_clk) begin
        if (w_en[slcs_pkg::ST_PP]) begin
            r_pplo_x  <= r_dcx_cl * r_ad1_cl[slcs_pkg::PP_SPLIT-1:0];
            r_pphi_x  <= r_dcx_cl * r_ad1_cl[slcs_pkg::D1M_W-1:slcs_pkg::PP_SPLIT];
            r_pplo_y  <= r_dcy_cl * r_ad1_cl[slcs_pkg::PP_SPLIT-1:0];
            r_pphi_y  <= r_dcy_cl * r_ad1_cl[slcs_pkg::D1M_W-1:slcs_pkg::PP_SPLIT];
            r_adm_pp  <= r_adm_cl;
            r_side_pp <= r_side_cl;
        end
    end

    // rounded dividend 2|num| + |den| and divisor 2|den|
    assign w_an_x = {r_pphi_x, {slcs_pkg::PP_SPLIT{1'b0}}} + slcs_pkg::AN_W'(r_pplo_x);
    assign w_an_y = {r_pphi_y, {slcs_pkg::PP_SPLIT{1'b0}}} + slcs_pkg::AN_W'(r_pplo_y);

    always_ff @(posedge i_clk) begin
        if (w_en[slcs_pkg::ST_ND]) begin
            r_num_x   <= {w_an_x, 1'b0} + slcs_pkg::NUM_W'(r_adm_pp);
            r_num_y   <= {w_an_y, 1'b0} + slcs_pkg::NUM_W'(r_adm_pp);
            r_den_nd  <= {r_adm_pp, 1'b0};
            r_side_nd <= r_side_pp;
        end
    end

    // crossing point quotients
    slcs_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en[slcs_pkg::ST_DIV0 +: slcs_pkg::QUO_W]),
        .i_num (r_num_x),
        .i_den (r_den_nd),
        .o_quo (w_qx)
    );

    slcs_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en[slcs_pkg::ST_DIV0 +: slcs_pkg::QUO_W]),
        .i_num (r_num_y),
        .i_den (r_den_nd),
        .o_quo (w_qy)
    );

    // side information rides alongside the divider
    always_ff @(posedge i_clk) begin
        if (w_en[slcs_pkg::ST_DIV0]) begin
            r_side_dv[0] <= r_side_nd;
        end
        for (int j = 1; j < slcs_pkg::QUO_W; j++) begin
            if (w_en[slcs_pkg::ST_DIV0 + j]) begin
                r_side_dv[j] <= r_side_dv[j-1];
            end
        end
    end

    // crossing point and result assembly
    assign w_last = r_side_dv[slcs_pkg::QUO_W-1];
    assign w_cx = w_last.seg.x1 + $signed(w_last.neg_x ? -w_qx : w_qx);
    assign w_cy = w_last.seg.y1 + $signed(w_last.neg_y ? -w_qy : w_qy);

    always_comb begin
        n_out.code  = w_last.code;
        n_out.kept  = w_last.seg;
        n_out.piece = '0;
        if (w_last.code == slcs_pkg::CODE_CUT) begin
            if (w_last.start_front) begin
                n_out.kept.x1  = w_cx;
                n_out.kept.y1  = w_cy;
                n_out.piece.x0 = w_cx;
                n_out.piece.y0 = w_cy;
                n_out.piece.x1 = w_last.seg.x1;
                n_out.piece.y1 = w_last.seg.y1;
            end else begin
                n_out.kept.x0  = w_cx;
                n_out.kept.y0  = w_cy;
                n_out.piece.x0 = w_last.seg.x0;
                n_out.piece.y0 = w_last.seg.y0;
                n_out.piece.x1 = w_cx;
                n_out.piece.y1 = w_cy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[slcs_pkg::NST-1]) begin
            r_out <= n_out;
        end
    end

    // result channel
    assign o_res.valid     = r_vld[slcs_pkg::NST-1];
    assign o_res.side_code = r_out.code;
    assign o_res.kept_x0   = r_out.kept.x0;
    assign o_res.kept_y0   = r_out.kept.y0;
    assign o_res.kept_x1   = r_out.kept.x1;
    assign o_res.kept_y1   = r_out.kept.y1;
    assign o_res.piece_x0  = r_out.piece.x0;
    assign o_res.piece_y0  = r_out.piece.y0;
    assign o_res.piece_x1  = r_out.piece.x1;
    assign o_res.piece_y1  = r_out.piece.y1;

    // result and transfer terms for the checks below
    assign w_chk_cut     = o_res.valid && (o_res.side_code == slcs_pkg::CODE_CUT);
    assign w_chk_whole   = o_res.valid && (o_res.side_code != slcs_pkg::CODE_CUT);
    assign w_cut_joins   = ((o_res.kept_x1 == o_res.piece_x0)
                            && (o_res.kept_y1 == o_res.piece_y0))
                         || ((o_res.kept_x0 == o_res.piece_x1)
                            && (o_res.kept_y0 == o_res.piece_y1));
    assign w_piece_clear = (o_res.piece_x0 == '0) && (o_res.piece_y0 == '0)
                         && (o_res.piece_x1 == '0) && (o_res.piece_y1 == '0);
    assign w_seg_take    = i_seg.valid && i_seg.ready;

    // split parts share the crossing point
    `SLCS_ASSERT_SAME(a_split_joins, i_clk, i_rst_n, w_chk_cut, w_cut_joins, "split parts apart")

    // piece stays zero unless split
    `SLCS_ASSERT_SAME(a_piece_zero, i_clk, i_rst_n, w_chk_whole, w_piece_clear, "piece not zero")

    // an input transfer always lands in the first stage
    `SLCS_ASSERT_NEXT(a_take_lands, i_clk, i_rst_n, w_seg_take, r_vld[0], "segment lost")

endmodule

/* rtl/core/slcs_div.sv */
// pipelined restoring divider, one quotient bit per stage, no reset needed
// depends on slcs_pkg; stage enables come from the top level flow control
module slcs_div (
    input  logic                         i_clk,
    input  logic [slcs_pkg::QUO_W-1:0]   i_en,
    input  logic [slcs_pkg::NUM_W-1:0]   i_num,
    input  logic [slcs_pkg::DEN_W-1:0]   i_den,
    output logic [slcs_pkg::QUO_W-1:0]   o_quo
);

    logic [slcs_pkg::NUM_W-1:0] r_rem [slcs_pkg::QUO_W-1];
    logic [slcs_pkg::DEN_W-1:0] r_den [slcs_pkg::QUO_W-1];
    logic [slcs_pkg::QUO_W-1:0] r_quo [slcs_pkg::QUO_W];

    for (genvar j = 0; j < slcs_pkg::QUO_W; j++) begin : g_step
        logic [slcs_pkg::NUM_W-1:0] w_rem_in;
        logic [slcs_pkg::NUM_W-1:0] w_dsh;
        logic [slcs_pkg::DEN_W-1:0] w_den_in;
        logic [slcs_pkg::QUO_W-1:0] w_quo_in;
        logic                       w_bit;

        // operands from the input or the previous stage
        if (j == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_den_in = r_den[j-1];
            assign w_quo_in = r_quo[j-1];
        end

        // trial subtract of the divisor aligned to this quotient bit
        assign w_dsh = slcs_pkg::NUM_W'(w_den_in) << (slcs_pkg::QUO_W - 1 - j);
        assign w_bit = (w_rem_in >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_quo[j] <= {w_quo_in[slcs_pkg::QUO_W-2:0], w_bit};
            end
        end

        // the last stage keeps only the quotient
        if (j < slcs_pkg::QUO_W - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j] <= w_bit ? (w_rem_in - w_dsh) : w_rem_in;
                    r_den[j] <= w_den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[slcs_pkg::QUO_W-1];

endmodule

/* test/testbench.sv */
// self-checking testbench for segment_line_classify_split_top: directed table, then random phases
// depends on slcs_pkg, slcs_seg_if, slcs_res_if, slcs_cfg_if and the block itself
module testbench;

    localparam int LATENCY     = 22;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 62;
    localparam int NUM_PHASES  = 8;
    localparam int REPORT_MAX  = 10;

    // segment on its way in, with an expectation typed in by hand where known
    typedef struct packed {
        logic           typed;
        slcs_pkg::t_res res;
    } t_sent;

    // one row of the directed table: a line load or a segment
    typedef struct {
        logic           is_line;
        logic [15:0]    nx;
        logic [15:0]    ny;
        logic [31:0]    off;
        logic [19:0]    thk;
        slcs_pkg::t_seg seg;
        logic           typed;
        slcs_pkg::t_res res;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    slcs_seg_if seg_ch();
    slcs_res_if res_ch();
    slcs_cfg_if cfg_ch();

    logic take_q    = 1'b0;
    int   gap_pct   = 0;
    int   stall_pct = 0;

    assign res_ch.ready = take_q;

    segment_line_classify_split_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // line as the block should hold it
    logic signed [15:0] line_nx  = slcs_pkg::NORMAL_X_RST;
    logic signed [15:0] line_ny  = slcs_pkg::NORMAL_Y_RST;
    logic signed [31:0] line_off = slcs_pkg::LINE_OFFSET_RST;
    logic [19:0]        line_thk = slcs_pkg::THICKNESS_RST;

    t_sent          sent_segments[$];
    slcs_pkg::t_res clipped_due[$];
    t_stim_row      stim_table[$];

    int bad_results  = 0;
    int results_seen = 0;
    int lines_loaded = 0;
    int quiet_cycles = 0;
    int code_count[4] = '{0, 0, 0, 0};

    // 1 front, -1 back, 0 inside the band
    function automatic int side_of(longint d);
        longint band;
        band = longint'({44'd0, line_thk});
        if (d > band)
            return 1;
        if (d < -band)
            return -1;
        return 0;
    endfunction

    // c1 + (c0 - c1) * d1 / den, quotient rounded half away from zero
    function automatic logic signed [15:0] cut_coord(longint c0, longint c1, longint d1,
                                                     longint den);
        longint     num;
        longint     q;
        longint     c;
        logic [63:0] an;
        logic [63:0] ad;
        logic        neg;
        num = (c0 - c1) * d1;
        neg = (num < 0) != (den < 0);
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        q   = longint'((64'd2 * an + ad) / (64'd2 * ad));
        c   = c1 + (neg ? -q : q);
        return c[15:0];
    endfunction

    // classify a segment against the held line and cut it on a crossing
    function automatic slcs_pkg::t_res clip_segment(slcs_pkg::t_seg s);
        longint x0, y0, x1, y1, d0, d1;
        int     s0, s1;
        logic signed [15:0] cx, cy;
        slcs_pkg::t_res r;
        x0 = longint'($signed(s.x0));
        y0 = longint'($signed(s.y0));
        x1 = longint'($signed(s.x1));
        y1 = longint'($signed(s.y1));
        d0 = longint'(line_nx) * x0 + longint'(line_ny) * y0 + longint'(line_off);
        d1 = longint'(line_nx) * x1 + longint'(line_ny) * y1 + longint'(line_off);
        s0 = side_of(d0);
        s1 = side_of(d1);
        r.kept  = s;
        r.piece = '0;
        if (s0 + s1 != 0) begin
            r.code = (s0 + s1 > 0) ? slcs_pkg::CODE_FRONT : slcs_pkg::CODE_BACK;
        end else if (s0 == 0) begin
            r.code = slcs_pkg::CODE_ON;
        end else begin
            cx = cut_coord(x0, x1, d1, d1 - d0);
            cy = cut_coord(y0, y1, d1, d1 - d0);
            r.code = slcs_pkg::CODE_CUT;
            if (s0 > 0) begin
                r.kept.x1  = cx;
                r.kept.y1  = cy;
                r.piece.x0 = cx;
                r.piece.y0 = cy;
                r.piece.x1 = s.x1;
                r.piece.y1 = s.y1;
            end else begin
                r.piece.x0 = s.x0;
                r.piece.y0 = s.y0;
                r.piece.x1 = cx;
                r.piece.y1 = cy;
                r.kept.x0  = cx;
                r.kept.y0  = cy;
            end
        end
        return r;
    endfunction

    function automatic slcs_pkg::t_seg mk_seg(int a, int b, int c, int d);
        slcs_pkg::t_seg s;
        s.x0 = a[15:0];
        s.y0 = b[15:0];
        s.x1 = c[15:0];
        s.y1 = d[15:0];
        return s;
    endfunction

    function automatic string show_res(slcs_pkg::t_res r);
        return $sformatf("code %0d kept (%0d,%0d)-(%0d,%0d) piece (%0d,%0d)-(%0d,%0d)",
                         r.code, $signed(r.kept.x0), $signed(r.kept.y0),
                         $signed(r.kept.x1), $signed(r.kept.y1),
                         $signed(r.piece.x0), $signed(r.piece.y0),
                         $signed(r.piece.x1), $signed(r.piece.y1));
    endfunction

    // directed table rows
    function automatic void add_line(int nx, int ny, int off, int thk);
        t_stim_row row;
        row = '{default: '0};
        row.is_line = 1'b1;
        row.nx  = nx[15:0];
        row.ny  = ny[15:0];
        row.off = off;
        row.thk = thk[19:0];
        stim_table.insert(stim_table.size(), row);
    endfunction

    function automatic void add_seg(slcs_pkg::t_seg s);
        t_stim_row row;
        row = '{default: '0};
        row.seg = s;
        stim_table.insert(stim_table.size(), row);
    endfunction

    function automatic void add_known(slcs_pkg::t_seg s, slcs_pkg::t_side_code c,
                                      slcs_pkg::t_seg k, slcs_pkg::t_seg p);
        t_stim_row row;
        row = '{default: '0};
        row.seg   = s;
        row.typed = 1'b1;
        row.res.code  = c;
        row.res.kept  = k;
        row.res.piece = p;
        stim_table.insert(stim_table.size(), row);
    endfunction

    // not cut: the segment comes back whole with an empty piece
    function automatic void add_whole(slcs_pkg::t_seg s, slcs_pkg::t_side_code c);
        add_known(s, c, s, '0);
    endfunction

    // coordinates: full range, near the origin, extremes, tiny
    function automatic logic [15:0] pick_coord();
        int r;
        case ($urandom_range(9))
            0, 1, 2, 3: r = $urandom;
            4, 5, 6, 7: r = $urandom_range(1024) - 512;
            8: begin
                case ($urandom_range(3))
                    0:       r = -32768;
                    1:       r = 32767;
                    2:       r = 0;
                    default: r = -1;
                endcase
            end
            default: r = $urandom_range(6) - 3;
        endcase
        return r[15:0];
    endfunction

    function automatic slcs_pkg::t_seg random_segment();
        slcs_pkg::t_seg s;
        s.x0 = pick_coord();
        s.y0 = pick_coord();
        // mirrored end through the origin gives many crossings
        if ($urandom_range(7) == 0) begin
            s.x1 = -s.x0;
            s.y1 = -s.y0;
        end else begin
            s.x1 = pick_coord();
            s.y1 = pick_coord();
        end
        return s;
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        take_q <= ($urandom_range(99) >= stall_pct);
    end

    // transfer tracking: results checked, segments predicted, line mirrored
    always @(posedge i_clk) begin
        slcs_pkg::t_res got;
        slcs_pkg::t_res want;
        slcs_pkg::t_seg in_seg;
        t_sent          row;
        logic           bad;
        if (!i_rst_n) begin
            line_nx  = slcs_pkg::NORMAL_X_RST;
            line_ny  = slcs_pkg::NORMAL_Y_RST;
            line_off = slcs_pkg::LINE_OFFSET_RST;
            line_thk = slcs_pkg::THICKNESS_RST;
        end else begin
            // result transfer
            if (res_ch.valid && res_ch.ready) begin
                got.code     = slcs_pkg::t_side_code'(res_ch.side_code);
                got.kept.x0  = res_ch.kept_x0;
                got.kept.y0  = res_ch.kept_y0;
                got.kept.x1  = res_ch.kept_x1;
                got.kept.y1  = res_ch.kept_y1;
                got.piece.x0 = res_ch.piece_x0;
                got.piece.y0 = res_ch.piece_y0;
                got.piece.x1 = res_ch.piece_x1;
                got.piece.y1 = res_ch.piece_y1;
                results_seen++;
                code_count[got.code]++;
                if (clipped_due.size() == 0) begin
                    bad_results++;
                    if (bad_results <= REPORT_MAX)
                        $display("result with nothing due: %s", show_res(got));
                end else begin
                    want = clipped_due.pop_front();
                    bad = (got.code !== want.code)
                        || (got.kept.x0 !== want.kept.x0) || (got.kept.y0 !== want.kept.y0)
                        || (got.kept.x1 !== want.kept.x1) || (got.kept.y1 !== want.kept.y1)
                        || (got.piece.x0 !== want.piece.x0) || (got.piece.y0 !== want.piece.y0)
                        || (got.piece.x1 !== want.piece.x1) || (got.piece.y1 !== want.piece.y1);
                    if (bad) begin
                        bad_results++;
                        if (bad_results <= REPORT_MAX) begin
                            $display("result %0d mismatch", results_seen);
                            $display("  expected %s", show_res(want));
                            $display("  actual   %s", show_res(got));
                        end
                    end
                end
            end
            // segment transfer
            if (seg_ch.valid && seg_ch.ready) begin
                in_seg.x0 = seg_ch.start_x;
                in_seg.y0 = seg_ch.start_y;
                in_seg.x1 = seg_ch.end_x;
                in_seg.y1 = seg_ch.end_y;
                row = sent_segments.pop_front();
                clipped_due.insert(clipped_due.size(),
                                   row.typed ? row.res : clip_segment(in_seg));
            end
            // register write
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (slcs_pkg::t_cfg_idx'(cfg_ch.index))
                    slcs_pkg::CFG_NORMAL_X:    line_nx  = cfg_ch.data[15:0];
                    slcs_pkg::CFG_NORMAL_Y:    line_ny  = cfg_ch.data[15:0];
                    slcs_pkg::CFG_LINE_OFFSET: line_off = cfg_ch.data;
                    slcs_pkg::CFG_THICKNESS:   line_thk = cfg_ch.data[19:0];
                    default: ;
                endcase
            end
        end
        // watchdog on cycles without any transfer
        if ((seg_ch.valid && seg_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("FAIL segment_line_classify_split_top");
            $finish;
        end
    end

    // one segment transfer, after an optional random gap
    task automatic send_segment(input slcs_pkg::t_seg s, input logic typed,
                                input slcs_pkg::t_res res);
        t_sent e;
        if ($urandom_range(99) < gap_pct) begin
            seg_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < gap_pct)
                @(posedge i_clk);
        end
        e.typed = typed;
        e.res   = res;
        sent_segments.insert(sent_segments.size(), e);
        seg_ch.valid   <= 1'b1;
        seg_ch.start_x <= s.x0;
        seg_ch.start_y <= s.y0;
        seg_ch.end_x   <= s.x1;
        seg_ch.end_y   <= s.y1;
        @(posedge i_clk);
        while (!seg_ch.ready)
            @(posedge i_clk);
    endtask

    // stop sending and wait until every result is back
    task automatic wait_drained();
        seg_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sent_segments.size() != 0 || clipped_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic put_reg(input slcs_pkg::t_cfg_idx idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
    endtask

    // all four registers back to back, valid held high across them
    task automatic load_line(input int nx, input int ny, input int off, input int thk);
        put_reg(slcs_pkg::CFG_NORMAL_X, {16'd0, nx[15:0]});
        put_reg(slcs_pkg::CFG_NORMAL_Y, {16'd0, ny[15:0]});
        put_reg(slcs_pkg::CFG_LINE_OFFSET, off);
        put_reg(slcs_pkg::CFG_THICKNESS, {12'd0, thk[19:0]});
        cfg_ch.valid <= 1'b0;
        lines_loaded++;
    endtask

    // stimulus
    initial begin
        int k;
        int n;
        int nx;
        int ny;
        int off;
        int thk;
        seg_ch.valid   <= 1'b0;
        seg_ch.start_x <= '0;
        seg_ch.start_y <= '0;
        seg_ch.end_x   <= '0;
        seg_ch.end_y   <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= slcs_pkg::CFG_NORMAL_X;
        cfg_ch.data    <= '0;
        i_rst_n        <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default line after reset: normal (1, 0), no offset, narrow band
        add_whole(mk_seg(0, -32768, 0, 32767), slcs_pkg::CODE_ON);
        add_whole(mk_seg(256, 0, 512, -5), slcs_pkg::CODE_FRONT);
        add_whole(mk_seg(-256, 7, -1, 9), slcs_pkg::CODE_BACK);
        add_whole(mk_seg(0, 100, 300, 7), slcs_pkg::CODE_FRONT);
        add_whole(mk_seg(-5, 3, 0, 0), slcs_pkg::CODE_BACK);
        add_whole(mk_seg(32767, -32768, 32767, 32767), slcs_pkg::CODE_FRONT);
        add_whole(mk_seg(-32768, 32767, -32768, -32768), slcs_pkg::CODE_BACK);
        // crossings, start behind and start in front
        add_known(mk_seg(-256, 0, 256, 0), slcs_pkg::CODE_CUT, mk_seg(0, 0, 256, 0),
                  mk_seg(-256, 0, 0, 0));
        add_known(mk_seg(100, 50, -100, 50), slcs_pkg::CODE_CUT, mk_seg(100, 50, 0, 50),
                  mk_seg(0, 50, -100, 50));
        // half-way ties, positive and negative
        add_known(mk_seg(-1, 1, 1, 0), slcs_pkg::CODE_CUT, mk_seg(0, 1, 1, 0),
                  mk_seg(-1, 1, 0, 1));
        add_known(mk_seg(-1, 0, 1, 1), slcs_pkg::CODE_CUT, mk_seg(0, 0, 1, 1),
                  mk_seg(-1, 0, 0, 0));
        add_seg(mk_seg(32767, -32768, -32768, 32767));
        // distance exactly on the band edge counts as on the line
        add_line(16384, 0, 0, 16384);
        add_whole(mk_seg(1, 5, -1, 7), slcs_pkg::CODE_ON);
        add_whole(mk_seg(2, 0, -1, 0), slcs_pkg::CODE_FRONT);
        add_whole(mk_seg(-2, 0, 1, 0), slcs_pkg::CODE_BACK);
        // normal outside the unit range, largest offset and band
        add_line(-32768, 16384, 32'h7fff_ffff, 1048575);
        add_seg(mk_seg(0, 0, -32768, -32768));
        add_seg(mk_seg(32767, 32767, -32768, 32767));
        add_seg(mk_seg(-32768, -32768, 32767, 32767));
        // most negative offset, zero band
        add_line(-32768, -32768, 32'h8000_0000, 0);
        add_whole(mk_seg(-32768, -32768, -32768, -32768), slcs_pkg::CODE_ON);
        add_seg(mk_seg(-32768, -32767, -32768, -32768));
        add_seg(mk_seg(-32768, -32768, 32767, 32767));

        foreach (stim_table[i]) begin
            if (stim_table[i].is_line) begin
                wait_drained();
                load_line(stim_table[i].nx, stim_table[i].ny, stim_table[i].off,
                          stim_table[i].thk);
            end else begin
                send_segment(stim_table[i].seg, stim_table[i].typed, stim_table[i].res);
            end
        end

        // random phases, each on its own line, cycling through four idle patterns
        for (k = 0; k < NUM_PHASES; k++) begin
            wait_drained();
            case (k % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 81; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 81; end
                default: begin gap_pct = 23; stall_pct = 23; end
            endcase
            off = $urandom_range(33554432) - 16777216;
            thk = $urandom_range(1048575);
            case (k)
                0: begin nx = 16384;  ny = 0;      thk = 4194; end
                1: begin nx = 0;      ny = -16384; end
                2: begin nx = -16384; ny = 16384;  thk = 0; end
                4: begin nx = $urandom; ny = $urandom; off = $urandom; end
                5: begin nx = 16384;  ny = -16384; off = 32'h7fff_ffff; thk = 1048575; end
                6: begin nx = -16384; ny = -16384; off = 32'h8000_0000; thk = 0; end
                default: begin
                    nx = $urandom_range(32768) - 16384;
                    ny = $urandom_range(32768) - 16384;
                end
            endcase
            load_line(nx, ny, off, thk);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_segment(random_segment(), 1'b0, '0);
        end

        // drain and let any stray result show up
        wait_drained();
        gap_pct   = 0;
        stall_pct = 0;
        repeat (2 * LATENCY) @(posedge i_clk);
        if (clipped_due.size() != 0) begin
            $display("%0d results never arrived", clipped_due.size());
            bad_results += clipped_due.size();
        end

        $display("checked %0d results over %0d line settings, %0d mismatched",
                 results_seen, lines_loaded, bad_results);
        $display("sides seen: front %0d, back %0d, on line %0d, split %0d",
                 code_count[slcs_pkg::CODE_FRONT], code_count[slcs_pkg::CODE_BACK],
                 code_count[slcs_pkg::CODE_ON], code_count[slcs_pkg::CODE_CUT]);
        if (bad_results == 0)
            $display("PASS segment_line_classify_split_top");
        else
            $display("FAIL segment_line_classify_split_top");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/slcs_pkg.sv
rtl/core/slcs_seg_if.sv
rtl/core/slcs_res_if.sv
rtl/core/slcs_cfg_if.sv
rtl/core/slcs_div.sv
rtl/core/segment_line_classify_split_top.sv
test/testbench.sv
